// File: design/xrgb_line_scaler_top_macros.svh
// ----------------------------------------------------------------------------
// xrgb_line_scaler_top_macros.svh
// Assertion shorthands shared by the scaler modules. Each module provides clk
// and rst under those names.
// ----------------------------------------------------------------------------
`ifndef XRGB_LINE_SCALER_TOP_MACROS_SVH
`define XRGB_LINE_SCALER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define XLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define XLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/xls_pkg.sv
// ----------------------------------------------------------------------------
// xls_pkg
// Shared types, codes and the per-byte interpolation function of the scaler.
// ----------------------------------------------------------------------------
package xls_pkg;

  localparam int ACC_W  = 28;   // 12.16 position, upper bits masked off
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 12;   // width registers
  localparam int COL_W  = 11;
  localparam int PIX_W  = 32;
  localparam int BYTE_W = 8;
  localparam int WGT_W  = 8;
  localparam int LANES  = 4;    // bytes per pixel, X byte included

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [CFG_W-1:0] width_t;
  typedef logic [1:0]       mode_t;
  typedef logic [1:0]       reg_index_t;
  typedef logic [1:0]       req_code_t;

  localparam mode_t MODE_NEAREST  = 2'd0;
  localparam mode_t MODE_HLERP    = 2'd1;
  localparam mode_t MODE_BILINEAR = 2'd2;

  localparam reg_index_t REG_SRC_WIDTH  = 2'd0;
  localparam reg_index_t REG_DST_WIDTH  = 2'd1;
  localparam reg_index_t REG_SCALE_MODE = 2'd2;

  localparam req_code_t REQ_WR_UPPER = 2'd0;
  localparam req_code_t REQ_WR_LOWER = 2'd1;
  localparam req_code_t REQ_PRODUCE  = 2'd2;

  localparam acc_t STEP_RESET = acc_t'(1 << FRAC_W);

  localparam logic signed [18:0] LERP_ROUND = 19'sd128;

  typedef enum logic [1:0] {
    KIND_WR_UPPER = 2'd0,
    KIND_WR_LOWER = 2'd1,
    KIND_PRODUCE  = 2'd2
  } req_kind_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixel;
    logic [WGT_W-1:0] wy;
  } req_entry_t;

  typedef struct packed {
    width_t src_eff;
    width_t dst_eff;
    mode_t  mode;
    acc_t   step;
    logic   restart;   // new line after a register write
    logic   hold;      // step size not yet valid
  } back_cfg_t;

  // a + floor(((b - a) * w + 128) / 256), clamped to 0..255
  function automatic logic [BYTE_W-1:0] lerp8(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [WGT_W-1:0]  w);
    logic signed [9:0]  diff;
    logic signed [18:0] prod;
    logic signed [10:0] delta;
    logic signed [10:0] sum;
    logic [BYTE_W-1:0]  res;
    diff  = $signed({2'b00, b}) - $signed({2'b00, a});
    prod  = $signed({{9{diff[9]}}, diff}) * $signed({11'd0, w}) + LERP_ROUND;
    delta = 11'(prod >>> 8);
    sum   = $signed({3'b000, a}) + delta;
    if (sum < 11'sd0) begin
      res = '0;
    end else if (sum > 11'sd255) begin
      res = '1;
    end else begin
      res = sum[BYTE_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/xls_front.sv
// ----------------------------------------------------------------------------
// xls_front
// Accepts requests, drops those that have no effect and queues the rest.
// ----------------------------------------------------------------------------
`include "xrgb_line_scaler_top_macros.svh"

module xls_front #(
  parameter int MAX_SRC_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [xls_pkg::COL_W-1:0]       column,
  input  logic [xls_pkg::PIX_W-1:0]       pixel,
  input  logic [xls_pkg::WGT_W-1:0]       vert_weight,
  input  logic                            pop,
  output logic                            q_valid,
  output xls_pkg::req_entry_t             q_entry
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xls_pkg::req_entry_t fifo [DEPTH];
  xls_pkg::req_entry_t entry;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                keep;
  logic                push;

  always_comb begin
    entry.column = column;
    entry.pixel  = pixel;
    entry.wy     = vert_weight;
    entry.kind   = xls_pkg::KIND_PRODUCE;
    keep         = 1'b0;
    unique case (req_type)
      xls_pkg::REQ_WR_UPPER: begin
        entry.kind = xls_pkg::KIND_WR_UPPER;
        keep       = 32'(column) < MAX_SRC_WIDTH;
      end
      xls_pkg::REQ_WR_LOWER: begin
        entry.kind = xls_pkg::KIND_WR_LOWER;
        keep       = 32'(column) < MAX_SRC_WIDTH;
      end
      xls_pkg::REQ_PRODUCE: begin
        entry.kind = xls_pkg::KIND_PRODUCE;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = (count == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign q_entry  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  `XLS_ASSERT(a_fifo_bound, count <= CNT_W'(DEPTH), "request queue overfilled")
  `XLS_ASSERT(a_pop_has_data, pop |-> q_valid, "back end popped an empty queue")

endmodule

// File: design/xls_step_div.sv
// ----------------------------------------------------------------------------
// xls_step_div
// Restoring divider for the position step: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "xrgb_line_scaler_top_macros.svh"

module xls_step_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  xls_pkg::acc_t   dividend,
  input  xls_pkg::width_t divisor,
  output logic            busy,
  output logic            done,
  output xls_pkg::acc_t   quotient
);

  localparam int STEPS = xls_pkg::ACC_W;
  localparam int CW    = $clog2(STEPS);

  logic [CW-1:0]             step_cnt;
  xls_pkg::acc_t             shreg;
  xls_pkg::width_t           rem;
  logic [xls_pkg::CFG_W:0]   rem_shift;
  logic [xls_pkg::CFG_W:0]   rem_diff;
  logic                      fits;

  always_comb begin
    rem_shift = {rem, shreg[xls_pkg::ACC_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
  end

  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + CW'(1);
        if (step_cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[xls_pkg::ACC_W-2:0], fits};
      rem   <= fits ? rem_diff[xls_pkg::CFG_W-1:0] : rem_shift[xls_pkg::CFG_W-1:0];
    end
  end

  `XLS_ASSERT(a_start_when_idle, start |-> !busy, "divider restarted while busy")
  `XLS_ASSERT(a_start_runs, start |=> busy, "divider did not start")

endmodule

// File: design/xls_back.sv
// ----------------------------------------------------------------------------
// xls_back
// Executes queued requests: row store writes and output pixel generation
// through a read, horizontal lerp and vertical lerp pipeline.
// ----------------------------------------------------------------------------
`include "xrgb_line_scaler_top_macros.svh"

module xls_back #(
  parameter int MAX_SRC_WIDTH,
  parameter int MAX_DST_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  xls_pkg::back_cfg_t        cfg,
  input  logic                      q_valid,
  input  xls_pkg::req_entry_t       q_entry,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [xls_pkg::PIX_W-1:0] pixel_out,
  output logic                      last_of_line
);

  localparam int AW   = $clog2(MAX_SRC_WIDTH);
  localparam int CNTW = $clog2(MAX_DST_WIDTH);
  localparam int BW   = xls_pkg::BYTE_W;

  logic [xls_pkg::PIX_W-1:0] upper_mem [MAX_SRC_WIDTH];
  logic [xls_pkg::PIX_W-1:0] lower_mem [MAX_SRC_WIDTH];

  logic            advance;
  logic            wr_upper;
  logic            wr_lower;
  logic            take_produce;
  logic            last;
  xls_pkg::width_t src_m1;
  xls_pkg::width_t dst_m1;
  xls_pkg::width_t col_raw;
  xls_pkg::width_t col0;
  xls_pkg::width_t col1;
  logic [AW-1:0]   rd_addr0;
  logic [AW-1:0]   rd_addr1;
  logic [AW-1:0]   wr_addr;
  xls_pkg::acc_t   acc;
  xls_pkg::acc_t   acc_next;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;

  // stage 1: store read data
  logic                      s1_valid;
  logic [xls_pkg::PIX_W-1:0] s1_up0;
  logic [xls_pkg::PIX_W-1:0] s1_up1;
  logic [xls_pkg::PIX_W-1:0] s1_lo0;
  logic [xls_pkg::PIX_W-1:0] s1_lo1;
  logic [xls_pkg::WGT_W-1:0] s1_wx;
  logic [xls_pkg::WGT_W-1:0] s1_wy;
  xls_pkg::mode_t            s1_mode;
  logic                      s1_last;

  // stage 2: horizontal results
  logic                      s2_valid;
  logic [xls_pkg::PIX_W-1:0] s2_top;
  logic [xls_pkg::PIX_W-1:0] s2_bot;
  logic [xls_pkg::PIX_W-1:0] s2_near;
  logic [xls_pkg::WGT_W-1:0] s2_wy;
  xls_pkg::mode_t            s2_mode;
  logic                      s2_last;

  logic [xls_pkg::PIX_W-1:0] hmix_top;
  logic [xls_pkg::PIX_W-1:0] hmix_bot;
  logic [xls_pkg::PIX_W-1:0] vmix;
  logic [xls_pkg::PIX_W-1:0] mix;

  always_comb begin
    advance      = !out_valid || !out_stall;
    pop          = q_valid && advance && !cfg.hold;
    wr_upper     = pop && (q_entry.kind == xls_pkg::KIND_WR_UPPER);
    wr_lower     = pop && (q_entry.kind == xls_pkg::KIND_WR_LOWER);
    take_produce = pop && (q_entry.kind == xls_pkg::KIND_PRODUCE);
    wr_addr      = AW'(q_entry.column);

    src_m1  = cfg.src_eff - xls_pkg::width_t'(1);
    dst_m1  = cfg.dst_eff - xls_pkg::width_t'(1);
    col_raw = acc[xls_pkg::FRAC_W +: xls_pkg::CFG_W];
    col0    = (col_raw > src_m1) ? src_m1 : col_raw;
    col1    = (col0 == src_m1) ? col0 : col0 + xls_pkg::width_t'(1);
    rd_addr0 = col0[AW-1:0];
    rd_addr1 = col1[AW-1:0];

    last       = xls_pkg::width_t'(count) >= dst_m1;
    acc_next   = last ? '0 : acc + cfg.step;
    count_next = last ? '0 : count + CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (cfg.restart) begin
      acc   <= '0;
      count <= '0;
    end else if (take_produce) begin
      acc   <= acc_next;
      count <= count_next;
    end
  end

  // row stores: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_upper) begin
      upper_mem[wr_addr] <= q_entry.pixel;
    end
    if (advance) begin
      s1_up0 <= upper_mem[rd_addr0];
      s1_up1 <= upper_mem[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_lower) begin
      lower_mem[wr_addr] <= q_entry.pixel;
    end
    if (advance) begin
      s1_lo0 <= lower_mem[rd_addr0];
      s1_lo1 <= lower_mem[rd_addr1];
    end
  end

  always_comb begin
    for (int k = 0; k < xls_pkg::LANES; k++) begin
      hmix_top[BW*k +: BW] = xls_pkg::lerp8(s1_up0[BW*k +: BW], s1_up1[BW*k +: BW], s1_wx);
      hmix_bot[BW*k +: BW] = xls_pkg::lerp8(s1_lo0[BW*k +: BW], s1_lo1[BW*k +: BW], s1_wx);
    end
  end

  always_comb begin
    for (int k = 0; k < xls_pkg::LANES; k++) begin
      vmix[BW*k +: BW] = xls_pkg::lerp8(s2_top[BW*k +: BW], s2_bot[BW*k +: BW], s2_wy);
    end
    unique case (s2_mode)
      xls_pkg::MODE_NEAREST:  mix = s2_near;
      xls_pkg::MODE_HLERP:    mix = s2_top;
      xls_pkg::MODE_BILINEAR: mix = vmix;
      default:                mix = s2_near;
    endcase
  end

  // the whole pipe moves while the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= take_produce;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_wx        <= acc[xls_pkg::FRAC_W-xls_pkg::WGT_W +: xls_pkg::WGT_W];
      s1_wy        <= q_entry.wy;
      s1_mode      <= cfg.mode;
      s1_last      <= last;
      s2_top       <= hmix_top;
      s2_bot       <= hmix_bot;
      s2_near      <= s1_up0;
      s2_wy        <= s1_wy;
      s2_mode      <= s1_mode;
      s2_last      <= s1_last;
      pixel_out    <= mix;
      last_of_line <= s2_last;
    end
  end

  `XLS_ASSERT(a_restart_clears, cfg.restart |=> (acc == '0 && count == '0), "line not restarted")
  `XLS_ASSERT(a_count_in_row, xls_pkg::width_t'(count) < cfg.dst_eff, "output count past row end")

endmodule

// File: design/xrgb_line_scaler_top.sv
// ----------------------------------------------------------------------------
// xrgb_line_scaler_top
// Horizontal XRGB line scaler with nearest, horizontal lerp and bilinear
// modes. Requests write an upper or lower row store entry or produce the next
// output pixel of the line; a four-entry queue separates request intake from
// execution, and the back end retires one request per cycle unless the output
// stalls or a step is being computed, so the sustained rate is one request per
// clock. A produce request passes through the store read, horizontal lerp and
// vertical lerp into the output register; an output stall freezes the whole
// back end pipe. Each write to a defined register restarts the line and
// recomputes the position step in a restoring divider that yields one quotient
// bit per cycle; while the divider runs the configuration port is not ready
// and queued requests wait.
// ----------------------------------------------------------------------------
module xrgb_line_scaler_top #(
  parameter int MAX_SRC_WIDTH = 2048,
  parameter int MAX_DST_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [xls_pkg::COL_W-1:0]       column,
  input  logic [xls_pkg::PIX_W-1:0]       pixel,
  input  logic [xls_pkg::WGT_W-1:0]       vert_weight,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [xls_pkg::PIX_W-1:0]       pixel_out,
  output logic                            last_of_line,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  xls_pkg::reg_index_t             cfg_index,
  input  logic [xls_pkg::CFG_W-1:0]       cfg_data
);

  xls_pkg::width_t     src_pixels;
  xls_pkg::width_t     dst_pixels;
  xls_pkg::mode_t      scale_mode;
  xls_pkg::acc_t       step;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  xls_pkg::acc_t       div_quot;
  xls_pkg::acc_t       dividend;
  xls_pkg::width_t     src_eff;
  xls_pkg::width_t     dst_eff;
  logic                cfg_write;
  logic                cfg_hit;
  xls_pkg::back_cfg_t  back_cfg;
  logic                q_valid;
  logic                pop;
  xls_pkg::req_entry_t q_entry;

  always_comb begin
    unique case (cfg_index) inside
      xls_pkg::REG_SRC_WIDTH, xls_pkg::REG_DST_WIDTH, xls_pkg::REG_SCALE_MODE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cfg_ready = !div_busy && !div_start && !div_done;
  assign cfg_write = cfg_valid && cfg_ready;

  // saturate widths into their legal ranges
  always_comb begin
    if (src_pixels == '0) begin
      src_eff = xls_pkg::width_t'(1);
    end else if (32'(src_pixels) > MAX_SRC_WIDTH) begin
      src_eff = xls_pkg::width_t'(MAX_SRC_WIDTH);
    end else begin
      src_eff = src_pixels;
    end
    if (dst_pixels == '0) begin
      dst_eff = xls_pkg::width_t'(1);
    end else if (32'(dst_pixels) > MAX_DST_WIDTH) begin
      dst_eff = xls_pkg::width_t'(MAX_DST_WIDTH);
    end else begin
      dst_eff = dst_pixels;
    end
    dividend = {src_eff, {xls_pkg::FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_pixels <= xls_pkg::width_t'(1);
      dst_pixels <= xls_pkg::width_t'(1);
      scale_mode <= xls_pkg::MODE_NEAREST;
      step       <= xls_pkg::STEP_RESET;
      div_start  <= 1'b0;
    end else begin
      div_start <= cfg_write && cfg_hit;
      if (cfg_write) begin
        unique case (cfg_index)
          xls_pkg::REG_SRC_WIDTH:  src_pixels <= cfg_data;
          xls_pkg::REG_DST_WIDTH:  dst_pixels <= cfg_data;
          xls_pkg::REG_SCALE_MODE: scale_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (div_done) begin
        step <= div_quot;
      end
    end
  end

  always_comb begin
    back_cfg.src_eff = src_eff;
    back_cfg.dst_eff = dst_eff;
    back_cfg.mode    = scale_mode;
    back_cfg.step    = step;
    back_cfg.restart = cfg_write && cfg_hit;
    back_cfg.hold    = div_start || div_busy || div_done;
  end

  xls_step_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dst_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  xls_front #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .column      (column),
    .pixel       (pixel),
    .vert_weight (vert_weight),
    .pop         (pop),
    .q_valid     (q_valid),
    .q_entry     (q_entry)
  );

  xls_back #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_DST_WIDTH (MAX_DST_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (back_cfg),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .last_of_line (last_of_line)
  );

endmodule

// File: tb/sv/tb_xrgb_line_scaler_top.sv
// ----------------------------------------------------------------------------
// tb_xrgb_line_scaler_top
// Self-checking bench for the XRGB line scaler. A directed plan covers reset
// values, field extremes, every request type and every scale mode. Random
// phases then reprogram the widths and mode and mix row writes with produce
// requests. A shadow copy of the row stores and line position predicts every
// output pixel, and random gaps and stalls fall on both streams.
// ----------------------------------------------------------------------------
module tb_xrgb_line_scaler_top;
  import xls_pkg::*;

  localparam int ROW_DEPTH     = 2048;
  localparam int DST_LIMIT     = 2048;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1500000;

  // codes that the package leaves unnamed
  localparam mode_t      MODE_ALIAS_NEAREST = 2'd3;
  localparam req_code_t  REQ_IGNORED        = 2'd3;
  localparam reg_index_t REG_UNUSED         = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } scaled_px_t;

  // code is a request type for request rows and a register index for
  // register rows; val carries the pixel or the register data
  typedef struct packed {
    bit               is_cfg;
    logic [1:0]       code;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] val;
    logic [WGT_W-1:0] wy;
    bit               typed;
    logic [PIX_W-1:0] t_pix;
    bit               t_last;
  } plan_row_t;

  localparam int PLAN_LEN = 31;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    '{1'b0, REQ_WR_UPPER,   11'd0,    32'hffff_ffff, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0000_0000, 8'h00, 1'b1, 32'hffff_ffff, 1'b1},
    '{1'b0, REQ_WR_UPPER,   11'd0,    32'h0000_0000, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'hffff_ffff, 8'hff, 1'b1, 32'h0, 1'b1},
    '{1'b0, REQ_IGNORED,    11'd2047, 32'hffff_ffff, 8'hff, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_WR_UPPER,   11'd1,    32'hff00_ff00, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_WR_LOWER,   11'd0,    32'h00ff_00ff, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_WR_LOWER,   11'd1,    32'h80ff_7f01, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_WR_UPPER,   11'd2047, 32'h5a5a_5a5a, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_WR_LOWER,   11'd2047, 32'ha5a5_a5a5, 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SRC_WIDTH,  11'd0,    32'd2,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_DST_WIDTH,  11'd0,    32'd4,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SCALE_MODE, 11'd0,    32'(MODE_HLERP), 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SCALE_MODE, 11'd0,    32'(MODE_BILINEAR), 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'hff, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h80, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'hff, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SCALE_MODE, 11'd0,    32'(MODE_ALIAS_NEAREST), 8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SRC_WIDTH,  11'd0,    32'd0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_DST_WIDTH,  11'd0,    32'hfff,       8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_UNUSED,     11'd0,    32'hfff,       8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b1, REG_SRC_WIDTH,  11'd0,    32'hfff,       8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0},
    '{1'b0, REQ_PRODUCE,    11'd0,    32'h0,         8'h00, 1'b0, 32'h0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = REQ_WR_UPPER;
  logic [COL_W-1:0]   column = '0;
  logic [PIX_W-1:0]   pixel = '0;
  logic [WGT_W-1:0]   vert_weight = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic               last_of_line;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  reg_index_t         cfg_index = REG_SRC_WIDTH;
  logic [CFG_W-1:0]   cfg_data = '0;

  // shadow of the scaler state
  logic [PIX_W-1:0]   shadow_upper [0:ROW_DEPTH-1];
  logic [PIX_W-1:0]   shadow_lower [0:ROW_DEPTH-1];
  bit                 upper_written [0:ROW_DEPTH-1];
  bit                 lower_written [0:ROW_DEPTH-1];
  acc_t               acc_pos = '0;
  acc_t               acc_step = STEP_RESET;
  logic [COL_W-1:0]   line_count = '0;
  width_t             cfg_src = 12'd1;
  width_t             cfg_dst = 12'd1;
  mode_t              cfg_mode = MODE_NEAREST;

  scaled_px_t         pending_px [$];
  scaled_px_t         head_px;
  int                 errors = 0;
  int                 sent_items = 0;
  int                 cycle_count = 0;
  bit                 in_calm = 1'b0;
  bit                 out_calm = 1'b0;
  int                 stall_left = 0;
  int                 run_left = 0;

  xrgb_line_scaler_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .column       (column),
    .pixel        (pixel),
    .vert_weight  (vert_weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .last_of_line (last_of_line),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_src();
    if (cfg_src == 0) return 1;
    if (cfg_src > ROW_DEPTH) return ROW_DEPTH;
    return int'(cfg_src);
  endfunction

  function automatic int eff_dst();
    if (cfg_dst == 0) return 1;
    if (cfg_dst > DST_LIMIT) return DST_LIMIT;
    return int'(cfg_dst);
  endfunction

  // a + floor(((b - a) * w + 128) / 256)
  function automatic int blend8(input int a, input int b, input int w);
    int p;
    p = (b - a) * w + 128;
    return a + (p >>> 8);
  endfunction

  function automatic void read_columns(output int c, output int c1);
    int src;
    src = eff_src();
    c = int'(acc_pos >> FRAC_W);
    if (c > src - 1) c = src - 1;
    c1 = (c + 1 < src) ? c + 1 : c;
  endfunction

  // compute the next output pixel and advance the line position
  function automatic scaled_px_t next_scaled_pixel(input logic [WGT_W-1:0] wy);
    scaled_px_t px;
    int c, c1, wx, t, b;
    read_columns(c, c1);
    wx = int'((acc_pos >> 8) & 28'hff);
    if (cfg_mode == MODE_HLERP || cfg_mode == MODE_BILINEAR) begin
      for (int k = 0; k < LANES; k++) begin
        t = blend8(int'(shadow_upper[c][8*k +: 8]), int'(shadow_upper[c1][8*k +: 8]), wx);
        if (cfg_mode == MODE_BILINEAR) begin
          b = blend8(int'(shadow_lower[c][8*k +: 8]), int'(shadow_lower[c1][8*k +: 8]), wx);
          t = blend8(t, b, int'(wy));
        end
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        px.pix[8*k +: 8] = 8'(t);
      end
    end else begin
      px.pix = shadow_upper[c];
    end
    px.last = (int'(line_count) >= eff_dst() - 1);
    if (px.last) begin
      acc_pos = '0;
      line_count = '0;
    end else begin
      acc_pos = acc_pos + acc_step;
      line_count = line_count + 1'b1;
    end
    return px;
  endfunction

  function automatic void apply_register(input reg_index_t idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_SRC_WIDTH:  cfg_src = data;
      REG_DST_WIDTH:  cfg_dst = data;
      REG_SCALE_MODE: cfg_mode = data[1:0];
      default:        return;
    endcase
    acc_step = acc_t'((eff_src() << FRAC_W) / eff_dst());
    acc_pos = '0;
    line_count = '0;
  endfunction

  task automatic push_request(input req_code_t kind, input logic [COL_W-1:0] col,
                              input logic [PIX_W-1:0] pix, input logic [WGT_W-1:0] wy,
                              input bit typed, input scaled_px_t typed_px);
    int gap;
    gap = in_calm ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    req_type    <= kind;
    column      <= col;
    pixel       <= pix;
    vert_weight <= wy;
    do @(posedge clk); while (in_stall !== 1'b0);
    case (kind)
      REQ_WR_UPPER: begin
        shadow_upper[col] = pix;
        upper_written[col] = 1'b1;
      end
      REQ_WR_LOWER: begin
        shadow_lower[col] = pix;
        lower_written[col] = 1'b1;
      end
      REQ_PRODUCE: begin
        if (typed) begin
          void'(next_scaled_pixel(wy));
          pending_px.push_back(typed_px);
        end else begin
          pending_px.push_back(next_scaled_pixel(wy));
        end
      end
      default: ;
    endcase
    if (kind != REQ_IGNORED) sent_items++;
  endtask

  // write any store entry that the next produce request will read
  task automatic fill_before_produce();
    int c, c1;
    bit horiz;
    read_columns(c, c1);
    horiz = (cfg_mode == MODE_HLERP || cfg_mode == MODE_BILINEAR);
    if (!upper_written[c])
      push_request(REQ_WR_UPPER, COL_W'(c), $urandom, 8'($urandom), 1'b0, '0);
    if (horiz && !upper_written[c1])
      push_request(REQ_WR_UPPER, COL_W'(c1), $urandom, 8'($urandom), 1'b0, '0);
    if (cfg_mode == MODE_BILINEAR && !lower_written[c])
      push_request(REQ_WR_LOWER, COL_W'(c), $urandom, 8'($urandom), 1'b0, '0);
    if (cfg_mode == MODE_BILINEAR && !lower_written[c1])
      push_request(REQ_WR_LOWER, COL_W'(c1), $urandom, 8'($urandom), 1'b0, '0);
  endtask

  // registers change only with the block drained and quiet
  task automatic write_register(input reg_index_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return 12'd0;
        1:       return 12'd1;
        2:       return 12'd2;
        3:       return 12'd2048;
        default: return 12'hfff;
      endcase
    end
    if (r < 80) return CFG_W'($urandom_range(1, 12));
    return CFG_W'($urandom_range(1, 4095));
  endfunction

  // output backpressure
  always @(negedge clk) begin
    if (rst || out_calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = gap_len();
      run_left = $urandom_range(1, 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_px.size() == 0) begin
        $error("pixel_out: no pixel expected, got %h last %b", pixel_out, last_of_line);
        errors++;
      end else begin
        head_px = pending_px.pop_front();
        if (pixel_out !== head_px.pix) begin
          $error("pixel_out: expected %h, got %h", head_px.pix, pixel_out);
          errors++;
        end
        if (last_of_line !== head_px.last) begin
          $error("last_of_line: expected %b, got %b", head_px.last, last_of_line);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("xrgb_line_scaler_top regression: fail");
      $finish;
    end
  end

  initial begin
    int base;
    int n;
    int r;
    int span;
    logic [COL_W-1:0] col;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) begin
        write_register(reg_index_t'(PLAN[i].code), CFG_W'(PLAN[i].val));
      end else begin
        if (PLAN[i].code == REQ_PRODUCE) fill_before_produce();
        push_request(req_code_t'(PLAN[i].code), PLAN[i].col, PLAN[i].val, PLAN[i].wy,
                     PLAN[i].typed, '{PLAN[i].t_pix, PLAN[i].t_last});
      end
    end

    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      write_register(REG_SRC_WIDTH, pick_width());
      write_register(REG_DST_WIDTH, pick_width());
      write_register(REG_SCALE_MODE, CFG_W'($urandom_range(0, 4095)));
      if ($urandom_range(0, 6) == 0) write_register(REG_UNUSED, CFG_W'($urandom));
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          fill_before_produce();
          push_request(REQ_PRODUCE, COL_W'($urandom), $urandom, 8'($urandom), 1'b0, '0);
        end else if (r < 92) begin
          // mostly stay inside the active row, sometimes anywhere in the store
          span = (eff_src() + 1 > ROW_DEPTH - 1) ? ROW_DEPTH - 1 : eff_src() + 1;
          col = ($urandom_range(0, 4) != 0) ? COL_W'($urandom_range(0, span))
                                            : COL_W'($urandom_range(0, ROW_DEPTH - 1));
          push_request((r < 71) ? REQ_WR_UPPER : REQ_WR_LOWER, col, $urandom,
                       8'($urandom), 1'b0, '0);
        end else begin
          push_request(REQ_IGNORED, COL_W'($urandom), $urandom, 8'($urandom), 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("xrgb_line_scaler_top regression: pass");
    end else begin
      $display("xrgb_line_scaler_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/xls_pkg.sv
design/xls_front.sv
design/xls_step_div.sv
design/xls_back.sv
design/xrgb_line_scaler_top.sv
tb/sv/tb_xrgb_line_scaler_top.sv
